// ----- src/ctwrl_pkg.sv -----
package ctwrl_pkg;

  // Field widths of the transaction payloads.
  localparam int OP_W     = 2;
  localparam int ID_W     = 10;
  localparam int TIME_W   = 48;
  localparam int LEN_W    = 16;
  localparam int CNT_W    = 10;
  localparam int VIOL_W   = 32;
  localparam int STATUS_W = 4;

  // Table geometry.
  localparam int MAX_CLIENTS = 32;
  localparam int SLOT_W      = $clog2(MAX_CLIENTS);
  localparam int TOTAL_W     = $clog2(MAX_CLIENTS + 1);

  // Configuration port geometry.
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  // Register reset values.
  localparam logic [15:0]      WINDOW_MS_RST = 16'd1000;
  localparam logic [CNT_W-1:0] MAX_MSGS_RST  = CNT_W'(10);
  localparam logic [LEN_W-1:0] MAX_PLEN_RST  = LEN_W'(4096);

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_BCAST  = 2'd2
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED     = 4'd0,
    ST_DUP       = 4'd1,
    ST_FULL      = 4'd2,
    ST_REMOVED   = 4'd3,
    ST_NOTFOUND  = 4'd4,
    ST_SENT      = 4'd5,
    ST_LIMITED   = 4'd6,
    ST_NOCLIENTS = 4'd7,
    ST_DROPPED   = 4'd8
  } status_t;

  // Register index, taken from paddr[3:2].
  typedef enum logic [1:0] {
    REG_WINDOW   = 2'd0,
    REG_MAX_MSGS = 2'd1,
    REG_MAX_PLEN = 2'd2
  } reg_idx_t;

  typedef enum logic {
    S_IDLE,
    S_WALK
  } fsm_state_t;

  // One table entry as held in the entry memory.
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] window_start;
    logic [CNT_W-1:0]  msg_count;
    logic [VIOL_W-1:0] violations;
  } entry_t;

  // Access request to the entry memory.
  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    entry_t            wr_data;
  } mem_req_t;

endpackage

// ----- src/ctwrl_if.sv -----
// Command channel: one transaction per add, remove or broadcast.
interface ctwrl_req_if;
  logic                           valid;
  logic                           ready;
  logic [ctwrl_pkg::OP_W-1:0]     opcode;
  logic [ctwrl_pkg::ID_W-1:0]     client_id;
  logic [ctwrl_pkg::TIME_W-1:0]   now_ms;
  logic [ctwrl_pkg::LEN_W-1:0]    payload_len;
  logic                           ends_with_nul;

  modport source (
    output valid, opcode, client_id, now_ms, payload_len, ends_with_nul,
    input  ready
  );
  modport sink (
    input  valid, opcode, client_id, now_ms, payload_len, ends_with_nul,
    output ready
  );
endinterface

// Result channel: one transaction per result, last marks the final one.
interface ctwrl_res_if;
  logic                            valid;
  logic                            ready;
  logic [ctwrl_pkg::ID_W-1:0]      out_client;
  logic [ctwrl_pkg::STATUS_W-1:0]  status;
  logic [ctwrl_pkg::VIOL_W-1:0]    violation_total;
  logic                            last;

  modport source (
    output valid, out_client, status, violation_total, last,
    input  ready
  );
  modport sink (
    input  valid, out_client, status, violation_total, last,
    output ready
  );
endinterface

// ----- src/ctwrl_entry_mem.sv -----
// Entry store: one write port and one read port, read data registered.
module ctwrl_entry_mem (
  input  logic                clk,
  input  ctwrl_pkg::mem_req_t req,
  output ctwrl_pkg::entry_t   rd_data
);
  import ctwrl_pkg::*;

  entry_t mem [MAX_CLIENTS];

  // Write port.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

// ----- src/client_table_window_rate_limiter_core.sv -----
// Client table with fixed-window rate limiting. Up to 32 client ids are kept
// newest first; entries live at fixed slots of a one-port-read, one-port-write
// memory and a small order list of slot numbers keeps the table order, so add
// and remove only reshuffle that list. Add and remove search the table one
// entry per cycle through the memory read port; an empty table needs no search
// and gives its result in the accept cycle. A broadcast emits one result per
// cycle while results are taken, and a dropped payload or an empty table gives
// its single result in the accept cycle. A new command is taken only when the
// previous one has finished and the result register is free or being drained.
// Configuration is written through the APB port at byte addresses 0, 4 and 8;
// the user writes it only while the block is idle; the block does not enforce it.
module client_table_window_rate_limiter_core (
  input  logic                                clk,
  input  logic                                rst,
  ctwrl_req_if.sink                           req,
  ctwrl_res_if.source                         res,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ctwrl_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [ctwrl_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [ctwrl_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                pready
);
  import ctwrl_pkg::*;

  // Configuration registers.
  logic [15:0]       window_ms;
  logic [CNT_W-1:0]  max_msgs;
  logic [LEN_W-1:0]  max_plen;

  // Control and captured command.
  fsm_state_t        state;
  fsm_state_t        state_next;
  opcode_t           op_q;
  logic [ID_W-1:0]   id_q;
  logic [TIME_W-1:0] now_q;
  logic [SLOT_W-1:0] idx;
  logic [SLOT_W-1:0] cur_slot;
  logic [TOTAL_W-1:0] total;
  logic [SLOT_W-1:0] order [MAX_CLIENTS];

  // Result register.
  logic                out_valid;
  logic [ID_W-1:0]     out_client_q;
  status_t             out_status_q;
  logic [VIOL_W-1:0]   out_viol_q;
  logic                out_last_q;

  // Memory access.
  mem_req_t mem_req;
  entry_t   rd_data;

  // Combinational control.
  logic               out_free;
  logic               in_ready;
  logic               accept;
  opcode_t            req_op;
  logic               drop;
  logic               last_pos;
  logic [TOTAL_W-1:0] total_m1;
  logic [SLOT_W-1:0]  next_slot;
  logic [SLOT_W-1:0]  new_slot;
  logic               walk_start;
  logic               walk_step;
  logic               walk_done;
  logic               ins_en;
  logic               rem_en;
  logic [ID_W-1:0]    ins_id;
  logic [TIME_W-1:0]  ins_now;
  logic               emit;
  logic [ID_W-1:0]    emit_client;
  status_t            emit_status;
  logic [VIOL_W-1:0]  emit_viol;
  logic               emit_last;

  // Broadcast update of the entry under the walk.
  logic [TIME_W-1:0]  diff;
  logic               expired;
  logic [CNT_W-1:0]   cnt_eff;
  logic               limited;
  entry_t             bcast_entry;

  ctwrl_entry_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  // APB configuration port.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_ms <= WINDOW_MS_RST;
      max_msgs  <= MAX_MSGS_RST;
      max_plen  <= MAX_PLEN_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx_t'(paddr[3:2]))
        REG_WINDOW:   window_ms <= pwdata[15:0];
        REG_MAX_MSGS: max_msgs  <= pwdata[CNT_W-1:0];
        REG_MAX_PLEN: max_plen  <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[3:2]))
      REG_WINDOW:   prdata = APB_DATA_W'(window_ms);
      REG_MAX_MSGS: prdata = APB_DATA_W'(max_msgs);
      REG_MAX_PLEN: prdata = APB_DATA_W'(max_plen);
      default:      prdata = '0;
    endcase
  end

  // Handshake and shared decode.
  assign out_free  = !out_valid || res.ready;
  assign in_ready  = (state == S_IDLE) && out_free;
  assign req.ready = in_ready;
  assign accept    = req.valid && in_ready;
  assign req_op    = opcode_t'(req.opcode);
  assign drop      = (req.payload_len == '0) || (req.payload_len > max_plen) ||
                     (req.ends_with_nul && (req.payload_len == LEN_W'(1)));
  assign total_m1  = total - TOTAL_W'(1);
  assign last_pos  = ({1'b0, idx} == total_m1);
  assign next_slot = order[idx + SLOT_W'(1)];
  assign new_slot  = order[total[SLOT_W-1:0]];

  // Window check and counter update for the entry read from memory.
  always_comb begin
    diff    = now_q - rd_data.window_start;
    expired = diff >= TIME_W'(window_ms);
    cnt_eff = expired ? '0 : rd_data.msg_count;
    limited = cnt_eff >= max_msgs;
    bcast_entry.id           = rd_data.id;
    bcast_entry.window_start = expired ? now_q : rd_data.window_start;
    bcast_entry.msg_count    = limited ? cnt_eff : cnt_eff + CNT_W'(1);
    bcast_entry.violations   = limited ? rd_data.violations + VIOL_W'(1)
                                       : rd_data.violations;
  end

  // Control outputs of the sequencer.
  always_comb begin
    walk_start  = 1'b0;
    walk_step   = 1'b0;
    walk_done   = 1'b0;
    ins_en      = 1'b0;
    rem_en      = 1'b0;
    ins_id      = id_q;
    ins_now     = now_q;
    emit        = 1'b0;
    emit_client = '0;
    emit_status = ST_ADDED;
    emit_viol   = '0;
    emit_last   = 1'b1;
    mem_req     = '0;

    unique case (state)
      S_IDLE: begin
        ins_id  = req.client_id;
        ins_now = req.now_ms;
        if (accept) begin
          case (req_op)
            OP_ADD: begin
              if (total == '0) begin
                ins_en      = 1'b1;
                emit        = 1'b1;
                emit_client = req.client_id;
                emit_status = ST_ADDED;
              end else begin
                walk_start = 1'b1;
              end
            end
            OP_REMOVE: begin
              if (total == '0) begin
                emit        = 1'b1;
                emit_client = req.client_id;
                emit_status = ST_NOTFOUND;
              end else begin
                walk_start = 1'b1;
              end
            end
            OP_BCAST: begin
              if (drop) begin
                emit        = 1'b1;
                emit_status = ST_DROPPED;
              end else if (total == '0) begin
                emit        = 1'b1;
                emit_status = ST_NOCLIENTS;
              end else begin
                walk_start = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end

      S_WALK: begin
        case (op_q)
          OP_ADD: begin
            if (rd_data.id == id_q) begin
              if (out_free) begin
                emit        = 1'b1;
                emit_client = id_q;
                emit_status = ST_DUP;
                emit_viol   = rd_data.violations;
                walk_done   = 1'b1;
              end
            end else if (last_pos) begin
              if (out_free) begin
                emit        = 1'b1;
                emit_client = id_q;
                walk_done   = 1'b1;
                if (total == TOTAL_W'(MAX_CLIENTS)) begin
                  emit_status = ST_FULL;
                end else begin
                  emit_status = ST_ADDED;
                  ins_en      = 1'b1;
                end
              end
            end else begin
              walk_step = 1'b1;
            end
          end
          OP_REMOVE: begin
            if (rd_data.id == id_q) begin
              if (out_free) begin
                emit        = 1'b1;
                emit_client = id_q;
                emit_status = ST_REMOVED;
                emit_viol   = rd_data.violations;
                rem_en      = 1'b1;
                walk_done   = 1'b1;
              end
            end else if (last_pos) begin
              if (out_free) begin
                emit        = 1'b1;
                emit_client = id_q;
                emit_status = ST_NOTFOUND;
                walk_done   = 1'b1;
              end
            end else begin
              walk_step = 1'b1;
            end
          end
          default: begin
            // Broadcast: one result and one write-back per entry.
            if (out_free) begin
              emit            = 1'b1;
              emit_client     = rd_data.id;
              emit_status     = limited ? ST_LIMITED : ST_SENT;
              emit_viol       = bcast_entry.violations;
              emit_last       = last_pos;
              mem_req.wr_en   = 1'b1;
              mem_req.wr_addr = cur_slot;
              mem_req.wr_data = bcast_entry;
              if (last_pos) begin
                walk_done = 1'b1;
              end else begin
                walk_step = 1'b1;
              end
            end
          end
        endcase
      end

      default: ;
    endcase

    // Read the first entry on a start, the next one on a step.
    if (walk_start) begin
      mem_req.rd_en   = 1'b1;
      mem_req.rd_addr = order[0];
    end else if (walk_step) begin
      mem_req.rd_en   = 1'b1;
      mem_req.rd_addr = next_slot;
    end

    // A new entry goes to the first free slot with cleared counters.
    if (ins_en) begin
      mem_req.wr_en                   = 1'b1;
      mem_req.wr_addr                 = new_slot;
      mem_req.wr_data.id              = ins_id;
      mem_req.wr_data.window_start    = ins_now;
      mem_req.wr_data.msg_count       = '0;
      mem_req.wr_data.violations      = '0;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (walk_start) state_next = S_WALK;
      S_WALK: if (walk_done)  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Captured command and walk position.
  always_ff @(posedge clk) begin
    if (walk_start) begin
      op_q     <= req_op;
      id_q     <= req.client_id;
      now_q    <= req.now_ms;
      idx      <= '0;
      cur_slot <= order[0];
    end else if (walk_step) begin
      idx      <= idx + SLOT_W'(1);
      cur_slot <= next_slot;
    end
  end

  // Order list: live slots first, free slots after them.
  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
      for (int i = 0; i < MAX_CLIENTS; i++) begin
        order[i] <= SLOT_W'(i);
      end
    end else if (ins_en) begin
      total    <= total + TOTAL_W'(1);
      order[0] <= new_slot;
      for (int i = 1; i < MAX_CLIENTS; i++) begin
        if (TOTAL_W'(i) <= total) begin
          order[i] <= order[i-1];
        end
      end
    end else if (rem_en) begin
      total <= total_m1;
      for (int i = 0; i < MAX_CLIENTS - 1; i++) begin
        if ((SLOT_W'(i) >= idx) && (TOTAL_W'(i) < total_m1)) begin
          order[i] <= order[i+1];
        end
      end
      // The freed slot moves to the head of the free part.
      for (int i = 0; i < MAX_CLIENTS; i++) begin
        if (TOTAL_W'(i) == total_m1) begin
          order[i] <= order[idx];
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_client_q <= emit_client;
      out_status_q <= emit_status;
      out_viol_q   <= emit_viol;
      out_last_q   <= emit_last;
    end
  end

  assign res.valid           = out_valid;
  assign res.out_client      = out_client_q;
  assign res.status          = out_status_q;
  assign res.violation_total = out_viol_q;
  assign res.last            = out_last_q;

endmodule

// ----- verif/client_table_window_rate_limiter_core_tb.sv -----
`timescale 1ns / 100ps

module client_table_window_rate_limiter_core_tb;
  import ctwrl_pkg::*;

  // Opcode value that the block must ignore.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  // A broadcast visits at most this many table entries.
  localparam int WALK_LIMIT = 32;
  // Cycles the block may still be busy after its last reply.
  localparam int SETTLE_CYCLES = 48;
  localparam int CYCLE_LIMIT = 1000000;

  // One live client as the shadow table holds it.
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] start;
    logic [CNT_W-1:0]  sent;
    logic [VIOL_W-1:0] viol;
  } roster_slot_t;

  // One reply that the block owes.
  typedef struct packed {
    logic [ID_W-1:0]   client;
    status_t           status;
    logic [VIOL_W-1:0] viol;
    logic              last;
  } reply_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  ctwrl_req_if req_bus ();
  ctwrl_res_if res_bus ();

  client_table_window_rate_limiter_core dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_bus),
    .res     (res_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow of the block's table and registers.
  roster_slot_t      client_roster[$];
  reply_t            replies_due[$];
  logic [15:0]       lim_window;
  logic [CNT_W-1:0]  lim_msgs;
  logic [LEN_W-1:0]  lim_plen;

  int unsigned error_count;
  int unsigned cycle_count = 0;
  int sender_idle_pct;
  int stall_pct;
  int hold_len;
  int hold_reqs;
  int hold_seen = 0;
  int hold_left = 0;
  logic [TIME_W-1:0] sim_now;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic flag_mismatch(input string what, input longint unsigned got,
                               input longint unsigned want);
    $display("[%0t] %s: got %0d, want %0d", $time, what, got, want);
    error_count++;
  endtask

  function automatic int find_client(input logic [ID_W-1:0] id);
    for (int i = 0; i < client_roster.size(); i++) begin
      if (client_roster[i].id == id) return i;
    end
    return -1;
  endfunction

  function automatic void owe_reply(input logic [ID_W-1:0] client, input status_t status,
                                    input logic [VIOL_W-1:0] viol, input logic last);
    reply_t r;
    r.client = client;
    r.status = status;
    r.viol = viol;
    r.last = last;
    replies_due.push_back(r);
  endfunction

  // Applies one accepted command to the shadow table and queues its replies.
  function automatic void apply_table_command(input logic [OP_W-1:0] op,
                                              input logic [ID_W-1:0] id,
                                              input logic [TIME_W-1:0] now,
                                              input logic [LEN_W-1:0] plen,
                                              input logic nul);
    int idx;
    int walk;
    roster_slot_t slot;
    logic [LEN_W-1:0] body_len;
    logic [TIME_W-1:0] age;
    case (op)
      OP_ADD: begin
        idx = find_client(id);
        if (idx >= 0) begin
          slot = client_roster[idx];
          owe_reply(id, ST_DUP, slot.viol, 1'b1);
        end else if (client_roster.size() >= MAX_CLIENTS) begin
          owe_reply(id, ST_FULL, '0, 1'b1);
        end else begin
          slot.id = id;
          slot.start = now;
          slot.sent = '0;
          slot.viol = '0;
          client_roster.push_front(slot);
          owe_reply(id, ST_ADDED, '0, 1'b1);
        end
      end
      OP_REMOVE: begin
        idx = find_client(id);
        if (idx < 0) begin
          owe_reply(id, ST_NOTFOUND, '0, 1'b1);
        end else begin
          slot = client_roster[idx];
          client_roster.delete(idx);
          owe_reply(id, ST_REMOVED, slot.viol, 1'b1);
        end
      end
      OP_BCAST: begin
        body_len = nul ? plen - 1'b1 : plen;
        if (plen == '0 || plen > lim_plen || body_len == '0) begin
          owe_reply('0, ST_DROPPED, '0, 1'b1);
        end else if (client_roster.size() == 0) begin
          owe_reply('0, ST_NOCLIENTS, '0, 1'b1);
        end else begin
          walk = (client_roster.size() < WALK_LIMIT) ? client_roster.size() : WALK_LIMIT;
          for (int i = 0; i < walk; i++) begin
            slot = client_roster[i];
            age = now - slot.start;
            // An expired window starts over at this broadcast.
            if (age >= {32'd0, lim_window}) begin
              slot.start = now;
              slot.sent = '0;
            end
            if (slot.sent >= lim_msgs) begin
              slot.viol = slot.viol + 1'b1;
              owe_reply(slot.id, ST_LIMITED, slot.viol, i == walk - 1);
            end else begin
              slot.sent = slot.sent + 1'b1;
              owe_reply(slot.id, ST_SENT, slot.viol, i == walk - 1);
            end
            client_roster[i] = slot;
          end
        end
      end
      default: begin
        // The unused opcode leaves the table alone and owes nothing.
      end
    endcase
  endfunction

  task automatic match_reply();
    reply_t want;
    if (replies_due.size() == 0) begin
      flag_mismatch("reply with none pending, status", res_bus.status, 0);
      return;
    end
    want = replies_due.pop_front();
    if (res_bus.out_client !== want.client)
      flag_mismatch("out_client", res_bus.out_client, want.client);
    if (res_bus.status !== want.status)
      flag_mismatch("status", res_bus.status, want.status);
    if (res_bus.violation_total !== want.viol)
      flag_mismatch("violation_total", res_bus.violation_total, want.viol);
    if (res_bus.last !== want.last)
      flag_mismatch("last", res_bus.last, want.last);
  endtask

  // Watch both channels: commands feed the shadow table, replies are checked.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_bus.valid && req_bus.ready)
        apply_table_command(req_bus.opcode, req_bus.client_id, req_bus.now_ms,
                            req_bus.payload_len, req_bus.ends_with_nul);
      if (res_bus.valid && res_bus.ready)
        match_reply();
    end
  end

  // Reply side: random stalls, plus a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = hold_len;
    end
    if (hold_left != 0) begin
      hold_left--;
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Stop a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Offers one command and returns at the edge where it is accepted.
  task automatic send_cmd(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                          input logic [TIME_W-1:0] now, input logic [LEN_W-1:0] plen,
                          input logic nul);
    while ($urandom_range(99) < sender_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
    end
    req_bus.valid <= 1'b1;
    req_bus.opcode <= op;
    req_bus.client_id <= id;
    req_bus.now_ms <= now;
    req_bus.payload_len <= plen;
    req_bus.ends_with_nul <= nul;
    do @(posedge clk); while (!req_bus.ready);
  endtask

  // Stops offering and waits until every owed reply has come back.
  task automatic wait_drained();
    req_bus.valid <= 1'b0;
    do @(posedge clk); while (replies_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write followed by a read back of the same register.
  task automatic cfg_write(input reg_idx_t idx, input logic [31:0] value);
    logic [31:0] mask;
    case (idx)
      REG_WINDOW:   mask = 32'h0000_FFFF;
      REG_MAX_MSGS: mask = 32'h0000_03FF;
      default:      mask = 32'h0000_FFFF;
    endcase
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_ADDR_W'({idx, 2'b00});
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_WINDOW:   lim_window = value[15:0];
      REG_MAX_MSGS: lim_msgs = value[CNT_W-1:0];
      default:      lim_plen = value[LEN_W-1:0];
    endcase
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if ((prdata & mask) !== (value & mask))
      flag_mismatch("register read back", prdata & mask, value & mask);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_limits(input logic [15:0] window, input logic [CNT_W-1:0] msgs,
                            input logic [LEN_W-1:0] plen);
    cfg_write(REG_WINDOW, {16'd0, window});
    cfg_write(REG_MAX_MSGS, {22'd0, msgs});
    cfg_write(REG_MAX_PLEN, {16'd0, plen});
  endtask

  // Moves the stimulus clock: mostly small steps, sometimes jumps or wild values.
  task automatic advance_time();
    int r;
    r = $urandom_range(99);
    if (r < 70) sim_now = sim_now + $urandom_range(8);
    else if (r < 90) sim_now = sim_now + $urandom_range(2000);
    else if (r < 97) sim_now = sim_now + $urandom;
    else sim_now = {16'($urandom), 32'($urandom)};
  endtask

  function automatic logic [LEN_W-1:0] pick_payload_len();
    int r;
    r = $urandom_range(99);
    if (r < 72) return LEN_W'($urandom_range(1, lim_plen));
    if (r < 80) return '0;
    if (r < 88) return lim_plen + LEN_W'($urandom_range(1, 50));
    if (r < 93) return LEN_W'(1);
    return LEN_W'($urandom);
  endfunction

  function automatic logic [ID_W-1:0] pick_client();
    if ($urandom_range(99) < 85) return ID_W'($urandom_range(39));
    return ID_W'($urandom_range(1023));
  endfunction

  // Mix of adds, removes and broadcasts with some noise; noise is not counted.
  task automatic run_random_traffic(input int n_items);
    int done;
    int r;
    roster_slot_t slot;
    logic [ID_W-1:0] id;
    done = 0;
    while (done < n_items) begin
      advance_time();
      r = $urandom_range(99);
      if (r < 38) begin
        send_cmd(OP_ADD, pick_client(), sim_now, LEN_W'($urandom), 1'($urandom));
        done++;
      end else if (r < 60) begin
        id = pick_client();
        if (client_roster.size() != 0 && $urandom_range(3) != 0) begin
          slot = client_roster[$urandom_range(client_roster.size() - 1)];
          id = slot.id;
        end
        send_cmd(OP_REMOVE, id, sim_now, LEN_W'($urandom), 1'($urandom));
        done++;
      end else if (r < 95) begin
        send_cmd(OP_BCAST, ID_W'($urandom), sim_now, pick_payload_len(), 1'($urandom));
        done++;
      end else begin
        send_cmd(OP_UNUSED, ID_W'($urandom), {16'($urandom), 32'($urandom)},
                 LEN_W'($urandom), 1'($urandom));
      end
    end
  endtask

  // Every opcode, payload drop rule, id extremes and time wrap under reset limits.
  task automatic test_basic_ops();
    send_cmd(OP_BCAST, 10'd0, 48'd0, 16'd10, 1'b0);
    send_cmd(OP_REMOVE, 10'd5, 48'd0, 16'd0, 1'b0);
    send_cmd(OP_ADD, 10'd0, 48'hFFFF_FFFF_FFFE, 16'd0, 1'b0);
    send_cmd(OP_ADD, 10'd1023, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 1'b1);
    send_cmd(OP_ADD, 10'd0, 48'd3, 16'd0, 1'b0);
    send_cmd(OP_BCAST, 10'd0, 48'd4, 16'd0, 1'b0);
    send_cmd(OP_BCAST, 10'd0, 48'd4, 16'd1, 1'b1);
    send_cmd(OP_BCAST, 10'd0, 48'd4, 16'd4097, 1'b0);
    send_cmd(OP_BCAST, 10'd0, 48'd4, 16'hFFFF, 1'b1);
    // Window start lies just before the wrap, so the age stays small.
    send_cmd(OP_BCAST, 10'd1023, 48'd5, 16'd4096, 1'b1);
    send_cmd(OP_BCAST, 10'd0, 48'd5, 16'd1, 1'b0);
    send_cmd(OP_UNUSED, 10'h3FF, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 1'b1);
    send_cmd(OP_REMOVE, 10'd0, 48'd6, 16'd0, 1'b0);
    send_cmd(OP_ADD, 10'd512, 48'd100, 16'd0, 1'b0);
    send_cmd(OP_BCAST, 10'd0, 48'd2000, 16'd2, 1'b1);
    wait_drained();
  endtask

  // Clients hit their limit, then a zero window that restarts every time.
  task automatic test_rate_limit();
    set_limits(16'hFFFF, 10'd1, 16'd4096);
    send_cmd(OP_BCAST, 10'd0, 48'd3000, 16'd8, 1'b0);
    send_cmd(OP_BCAST, 10'd0, 48'd3001, 16'd8, 1'b0);
    send_cmd(OP_BCAST, 10'd0, 48'd3002, 16'd8, 1'b1);
    send_cmd(OP_REMOVE, 10'd1023, 48'd3003, 16'd0, 1'b0);
    send_cmd(OP_ADD, 10'd512, 48'd3004, 16'd0, 1'b0);
    wait_drained();
    set_limits(16'd0, 10'd1, 16'd4096);
    send_cmd(OP_BCAST, 10'd0, 48'd3004, 16'd8, 1'b0);
    send_cmd(OP_BCAST, 10'd0, 48'd3004, 16'd8, 1'b0);
    wait_drained();
  endtask

  // Fill the table past its bound, walk it whole, then thin it out.
  task automatic test_fill_table();
    roster_slot_t slot;
    set_limits(16'd30, 10'd4, 16'd4096);
    repeat (40) begin
      advance_time();
      send_cmd(OP_ADD, ID_W'($urandom_range(1023)), sim_now, LEN_W'($urandom), 1'($urandom));
    end
    repeat (6) begin
      sim_now = sim_now + $urandom_range(12);
      send_cmd(OP_BCAST, ID_W'($urandom), sim_now, LEN_W'($urandom_range(2, 4096)),
               1'($urandom));
    end
    repeat (8) begin
      if (client_roster.size() != 0) begin
        slot = client_roster[$urandom_range(client_roster.size() - 1)];
        send_cmd(OP_REMOVE, slot.id, sim_now, LEN_W'($urandom), 1'($urandom));
      end
    end
    repeat (4) begin
      advance_time();
      send_cmd(OP_ADD, ID_W'($urandom_range(1023)), sim_now, LEN_W'($urandom), 1'($urandom));
    end
    wait_drained();
  endtask

  // Replies held off for a long stretch while broadcasts keep coming.
  task automatic test_backpressure();
    sender_idle_pct = 0;
    stall_pct = 0;
    hold_len = 400;
    hold_reqs++;
    repeat (12) begin
      sim_now = sim_now + $urandom_range(20);
      send_cmd(OP_BCAST, ID_W'($urandom), sim_now, LEN_W'($urandom_range(2, 4096)),
               1'($urandom));
    end
    wait_drained();
  endtask

  task automatic test_random_phase(input logic [15:0] window, input logic [CNT_W-1:0] msgs,
                                   input logic [LEN_W-1:0] plen, input int idle_pct,
                                   input int stall, input int n_items);
    set_limits(window, msgs, plen);
    sender_idle_pct = idle_pct;
    stall_pct = stall;
    run_random_traffic(n_items);
    wait_drained();
  endtask

  initial begin
    error_count = 0;
    sender_idle_pct = 0;
    stall_pct = 0;
    hold_len = 0;
    hold_reqs = 0;
    sim_now = '0;
    lim_window = WINDOW_MS_RST;
    lim_msgs = MAX_MSGS_RST;
    lim_plen = MAX_PLEN_RST;
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    req_bus.valid <= 1'b0;
    req_bus.opcode <= OP_ADD;
    req_bus.client_id <= '0;
    req_bus.now_ms <= '0;
    req_bus.payload_len <= '0;
    req_bus.ends_with_nul <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_basic_ops();
    test_rate_limit();
    test_fill_table();
    test_backpressure();
    test_random_phase(16'd20, 10'd2, 16'd300, 0, 0, 52);
    test_random_phase(16'hFFFF, 10'h3FF, 16'hFFFF, 74, 0, 52);
    test_random_phase(16'd1, 10'd0, 16'd1, 0, 74, 52);
    test_random_phase(16'd0, 10'd5, 16'd1000, 14, 14, 52);

    if (error_count == 0 && replies_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
